### hw/rtl/pwkd_pkg.sv
// pwkd_pkg: shared constants, register indexes and types of the pulse width decoder
// no dependencies; imported by every other file of the block but pwkd_near
`timescale 1ns / 1ps

package pwkd_pkg;

  // parameter defaults
  localparam int CODE_BITS_DEF  = 64;
  localparam int WIDTH_BITS_DEF = 16;

  // register file geometry
  localparam int CFG_W = 16;
  localparam int CNT_W = 8;
  localparam int IDX_W = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SHORT_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_WIDTH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH_TOL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_BITS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_PREAMBLE = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] SHORT_WIDTH_RST  = 16'd256;
  localparam logic [CFG_W-1:0] LONG_WIDTH_RST   = 16'd512;
  localparam logic [CFG_W-1:0] WIDTH_TOL_RST    = 16'd100;
  localparam logic [CNT_W-1:0] MIN_BITS_RST     = 8'd50;
  localparam logic [CNT_W-1:0] MIN_PREAMBLE_RST = 8'd8;

  // terminator threshold is long width plus this many tolerances
  localparam int TERM_TOL_MULT = 3;

  // saturation value of the pair and bit counters
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [CFG_W-1:0] short_width;
    logic [CFG_W-1:0] long_width;
    logic [CFG_W-1:0] width_tolerance;
    logic [CNT_W-1:0] min_frame_bits;
    logic [CNT_W-1:0] min_preamble_pairs;
  } pwkd_cfg_t;

endpackage

### hw/rtl/pwkd_if.sv
// pwkd_if: valid/ready channel interfaces for pulse beats and frame beats
// depends on pwkd_pkg for default widths
`timescale 1ns / 1ps

interface pwkd_pulse_if #(
  parameter int WIDTH_BITS = pwkd_pkg::WIDTH_BITS_DEF
);
  import pwkd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  pulse_level;
  logic [WIDTH_BITS-1:0] pulse_width;

  modport source (output valid, output pulse_level, output pulse_width, input ready);
  modport sink   (input valid, input pulse_level, input pulse_width, output ready);
endinterface

interface pwkd_frame_if #(
  parameter int CODE_BITS = pwkd_pkg::CODE_BITS_DEF
);
  import pwkd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] frame_code;
  logic [CNT_W-1:0]     frame_bits;

  modport source (output valid, output frame_code, output frame_bits, input ready);
  modport sink   (input valid, input frame_code, input frame_bits, output ready);
endinterface

### hw/rtl/pwkd_cfg_regs.sv
// pwkd_cfg_regs: configuration register file, write only
// depends on pwkd_pkg for register indexes, reset values and the config struct
`timescale 1ns / 1ps

module pwkd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pwkd_pkg::IDX_W-1:0] cfg_index,
  input  logic [pwkd_pkg::CFG_W-1:0] cfg_wdata,
  output pwkd_pkg::pwkd_cfg_t        cfg
);
  import pwkd_pkg::*;

  pwkd_cfg_t cfg_r;
  pwkd_cfg_t cfg_nxt;

  // decode the written register, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_WIDTH:  cfg_nxt.short_width        = cfg_wdata;
        REG_LONG_WIDTH:   cfg_nxt.long_width         = cfg_wdata;
        REG_WIDTH_TOL:    cfg_nxt.width_tolerance    = cfg_wdata;
        REG_MIN_BITS:     cfg_nxt.min_frame_bits     = cfg_wdata[CNT_W-1:0];
        REG_MIN_PREAMBLE: cfg_nxt.min_preamble_pairs = cfg_wdata[CNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_width        <= SHORT_WIDTH_RST;
      cfg_r.long_width         <= LONG_WIDTH_RST;
      cfg_r.width_tolerance    <= WIDTH_TOL_RST;
      cfg_r.min_frame_bits     <= MIN_BITS_RST;
      cfg_r.min_preamble_pairs <= MIN_PREAMBLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/pwkd_near.sv
// pwkd_near: width match, true when the absolute difference is below the tolerance
// no package dependency
`timescale 1ns / 1ps

module pwkd_near #(
  parameter int W = 16
) (
  input  logic [W-1:0] value,
  input  logic [W-1:0] nominal,
  input  logic [W-1:0] tol,
  output logic         hit
);

  logic [W-1:0] diff;

  // absolute difference and compare
  always_comb begin
    if (value > nominal) begin
      diff = value - nominal;
    end else begin
      diff = nominal - value;
    end
    hit = diff < tol;
  end

endmodule

### hw/rtl/pwkd_parser.sv
// pwkd_parser: preamble, data and terminator parsing of one registered pulse per cycle while step is high
// depends on pwkd_pkg and pwkd_near
`timescale 1ns / 1ps

module pwkd_parser #(
  parameter int CODE_BITS  = pwkd_pkg::CODE_BITS_DEF,
  parameter int WIDTH_BITS = pwkd_pkg::WIDTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwkd_pkg::pwkd_cfg_t        cfg,
  input  logic                       step,
  input  logic                       item_level,
  input  logic [WIDTH_BITS-1:0]      item_width,
  output logic                       emit,
  output logic [CODE_BITS-1:0]       emit_code,
  output logic [pwkd_pkg::CNT_W-1:0] emit_bits
);
  import pwkd_pkg::*;

  localparam int CMP_W = (WIDTH_BITS > CFG_W) ? WIDTH_BITS : CFG_W;
  localparam int LIM_W = CMP_W + 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREAMBLE,
    PH_DATA_HIGH,
    PH_DATA_LOW
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [WIDTH_BITS-1:0] last_high_r, last_high_nxt;
  logic [CNT_W-1:0]      pairs_r, pairs_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;
  logic [CNT_W-1:0]      bits_r, bits_nxt;

  logic [CMP_W-1:0] w_x, last_x, short_x, long_x, tol_x;
  logic             w_short, w_long, last_short, last_long;
  logic [LIM_W-1:0] term_limit;
  logic             is_term;

  // operands at a common compare width
  assign w_x     = CMP_W'(item_width);
  assign last_x  = CMP_W'(last_high_r);
  assign short_x = CMP_W'(cfg.short_width);
  assign long_x  = CMP_W'(cfg.long_width);
  assign tol_x   = CMP_W'(cfg.width_tolerance);

  pwkd_near #(.W(CMP_W)) u_w_short (
    .value(w_x), .nominal(short_x), .tol(tol_x), .hit(w_short)
  );
  pwkd_near #(.W(CMP_W)) u_w_long (
    .value(w_x), .nominal(long_x), .tol(tol_x), .hit(w_long)
  );
  pwkd_near #(.W(CMP_W)) u_last_short (
    .value(last_x), .nominal(short_x), .tol(tol_x), .hit(last_short)
  );
  pwkd_near #(.W(CMP_W)) u_last_long (
    .value(last_x), .nominal(long_x), .tol(tol_x), .hit(last_long)
  );

  // terminator threshold, wide enough never to wrap
  assign term_limit = LIM_W'(long_x) + LIM_W'(tol_x) * LIM_W'(TERM_TOL_MULT);
  assign is_term    = LIM_W'(w_x) >= term_limit;

  // next state of the parser for the pulse in the input register
  always_comb begin
    phase_nxt     = phase_r;
    last_high_nxt = last_high_r;
    pairs_nxt     = pairs_r;
    code_nxt      = code_r;
    bits_nxt      = bits_r;
    emit          = 1'b0;
    emit_code     = code_r;
    emit_bits     = bits_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (item_level && w_short) begin
          phase_nxt     = PH_PREAMBLE;
          last_high_nxt = item_width;
          pairs_nxt     = CNT_W'(1);
        end
      end
      PH_PREAMBLE: begin
        if (item_level) begin
          if (w_short || w_long) begin
            last_high_nxt = item_width;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else if (w_short && last_short) begin
          if (pairs_r != CNT_MAX) begin
            pairs_nxt = pairs_r + CNT_W'(1);
          end
        end else if (w_long && last_long) begin
          if (pairs_r >= cfg.min_preamble_pairs) begin
            phase_nxt = PH_DATA_HIGH;
            code_nxt  = '0;
            bits_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DATA_HIGH: begin
        if (item_level) begin
          if (is_term) begin
            // end of frame, report when long enough
            phase_nxt = PH_IDLE;
            emit      = bits_r >= cfg.min_frame_bits;
            code_nxt  = '0;
            bits_nxt  = '0;
            pairs_nxt = '0;
          end else begin
            last_high_nxt = item_width;
            phase_nxt     = PH_DATA_LOW;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DATA_LOW: begin
        phase_nxt = PH_IDLE;
        if (!item_level) begin
          if (last_short && w_short) begin
            code_nxt  = {code_r[CODE_BITS-2:0], 1'b0};
            phase_nxt = PH_DATA_HIGH;
          end else if (last_long && w_long) begin
            code_nxt  = {code_r[CODE_BITS-2:0], 1'b1};
            phase_nxt = PH_DATA_HIGH;
          end
          if (phase_nxt == PH_DATA_HIGH && bits_r != CNT_MAX) begin
            bits_nxt = bits_r + CNT_W'(1);
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (!step) begin
      emit = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      last_high_r <= '0;
      pairs_r     <= '0;
      code_r      <= '0;
      bits_r      <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      last_high_r <= last_high_nxt;
      pairs_r     <= pairs_nxt;
      code_r      <= code_nxt;
      bits_r      <= bits_nxt;
    end
  end

endmodule

### hw/rtl/pulse_width_keyfob_decoder.sv
// pulse_width_keyfob_decoder: top level, input register, parser and frame output register
// depends on pwkd_pkg, pwkd_if, pwkd_cfg_regs, pwkd_parser
`timescale 1ns / 1ps

// Usage
// in_pulse carries one beat per radio pulse: pulse_level (1 high, 0 low) and
// pulse_width in microseconds. out_frame carries one beat per reported frame:
// frame_code (newest decoded bit in bit 0) and frame_bits (saturating at 255).
// Both channels move a beat when valid and ready are high at a clock edge.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per cycle;
// the user must write them only while no pulse is in flight, which the block
// does not enforce; indexes past the last register are ignored. A pulse is
// held in the input register and parsed from there; a terminator that closes
// a frame of at least min_frame_bits bits sets out_frame.valid through the
// frame output register. Throughput is one pulse per cycle while out_frame
// does not stall with a frame waiting, set by the combinational parser step
// between the two registers. When out_frame stalls with a frame waiting, the
// pulse in the input register waits and in_pulse.ready falls until the frame
// beat is taken. Reset (rst_n low, synchronous) loads the register defaults,
// empties both registers and returns the parser to waiting for a preamble.
module pulse_width_keyfob_decoder #(
  parameter int CODE_BITS  = pwkd_pkg::CODE_BITS_DEF,
  parameter int WIDTH_BITS = pwkd_pkg::WIDTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pwkd_pulse_if.sink                 in_pulse,
  pwkd_frame_if.source               out_frame,
  input  logic                       cfg_we,
  input  logic [pwkd_pkg::IDX_W-1:0] cfg_index,
  input  logic [pwkd_pkg::CFG_W-1:0] cfg_wdata
);
  import pwkd_pkg::*;

  pwkd_cfg_t cfg;

  logic                  in_v_r;
  logic                  in_level_r;
  logic [WIDTH_BITS-1:0] in_width_r;
  logic                  in_fire;
  logic                  step;

  logic                  emit;
  logic [CODE_BITS-1:0]  emit_code;
  logic [CNT_W-1:0]      emit_bits;

  logic                  out_v_r;
  logic [CODE_BITS-1:0]  out_code_r;
  logic [CNT_W-1:0]      out_bits_r;

  pwkd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the held pulse is parsed when the output register can take a frame
  assign step           = in_v_r && (!out_v_r || out_frame.ready);
  assign in_pulse.ready = !in_v_r || step;
  assign in_fire        = in_pulse.valid && in_pulse.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_fire || (in_v_r && !step);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_level_r <= in_pulse.pulse_level;
      in_width_r <= in_pulse.pulse_width;
    end
  end

  pwkd_parser #(
    .CODE_BITS  (CODE_BITS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (step),
    .item_level (in_level_r),
    .item_width (in_width_r),
    .emit       (emit),
    .emit_code  (emit_code),
    .emit_bits  (emit_bits)
  );

  // frame output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_frame.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r <= emit_code;
      out_bits_r <= emit_bits;
    end
  end

  assign out_frame.valid      = out_v_r;
  assign out_frame.frame_code = out_code_r;
  assign out_frame.frame_bits = out_bits_r;

endmodule

### test/tb.sv
// tb: self-checking bench for pulse_width_keyfob_decoder; sends pulse beats, predicts frames
// depends on pwkd_pkg, pwkd_if and the decoder RTL
`timescale 1ns / 1ps

module tb;
  import pwkd_pkg::*;

  localparam logic HI = 1'b1;
  localparam logic LO = 1'b0;
  localparam logic [15:0] WMAX = 16'hffff;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_PREAMBLE,
    PH_DATA_HIGH,
    PH_DATA_LOW
  } parse_phase_t;

  typedef struct {
    logic [63:0] code;
    logic [7:0]  bits;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  pwkd_pulse_if pulse_ch ();
  pwkd_frame_if frame_ch ();

  pulse_width_keyfob_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pulse  (pulse_ch),
    .out_frame (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the decoder: registers and parser state
  pwkd_cfg_t    cfg_shadow;
  parse_phase_t parse_phase;
  logic [15:0]  last_high;
  logic [7:0]   pair_cnt;
  logic [63:0]  code_reg;
  logic [7:0]   bit_cnt;

  frame_beat_t frames_due[$];

  int  errors = 0;
  int  pulses_sent = 0;
  int  frames_checked = 0;
  int  settings_used = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_on = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus the long hold used by the pressure test
  always @(posedge clk) begin
    frame_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each frame beat with the oldest predicted frame
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && frame_ch.valid && frame_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame beat: frame_code %h frame_bits %0d",
               frame_ch.frame_code, frame_ch.frame_bits);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (frame_ch.frame_code !== want.code) begin
          $error("frame_code expected %h actual %h", want.code, frame_ch.frame_code);
          errors++;
        end
        if (frame_ch.frame_bits !== want.bits) begin
          $error("frame_bits expected %0d actual %0d", want.bits, frame_ch.frame_bits);
          errors++;
        end
        frames_checked++;
      end
    end
  end

  function automatic bit width_near(logic [15:0] w, logic [15:0] nom);
    logic [15:0] d;
    d = (w > nom) ? w - nom : nom - w;
    return d < cfg_shadow.width_tolerance;
  endfunction

  function automatic int term_limit();
    return int'(cfg_shadow.long_width) + TERM_TOL_MULT * int'(cfg_shadow.width_tolerance);
  endfunction

  // shift one decoded bit in, count saturates
  task automatic shift_bit(logic b);
    code_reg = {code_reg[62:0], b};
    if (bit_cnt != CNT_MAX) bit_cnt++;
  endtask

  // advance the shadow parser by one accepted pulse, queue any frame it reports
  task automatic track_pulse(logic level, logic [15:0] w);
    frame_beat_t f;
    case (parse_phase)
      PH_WAIT: begin
        if (level && width_near(w, cfg_shadow.short_width)) begin
          parse_phase = PH_PREAMBLE;
          last_high = w;
          pair_cnt = 8'd1;
        end
      end
      PH_PREAMBLE: begin
        if (level) begin
          if (width_near(w, cfg_shadow.short_width) || width_near(w, cfg_shadow.long_width))
            last_high = w;
          else
            parse_phase = PH_WAIT;
        end else if (width_near(w, cfg_shadow.short_width) &&
                     width_near(last_high, cfg_shadow.short_width)) begin
          if (pair_cnt != CNT_MAX) pair_cnt++;
        end else if (width_near(w, cfg_shadow.long_width) &&
                     width_near(last_high, cfg_shadow.long_width)) begin
          if (pair_cnt >= cfg_shadow.min_preamble_pairs) begin
            parse_phase = PH_DATA_HIGH;
            code_reg = '0;
            bit_cnt = '0;
          end else begin
            parse_phase = PH_WAIT;
          end
        end else begin
          parse_phase = PH_WAIT;
        end
      end
      PH_DATA_HIGH: begin
        if (!level) begin
          parse_phase = PH_WAIT;
        end else if (int'(w) >= term_limit()) begin
          parse_phase = PH_WAIT;
          if (bit_cnt >= cfg_shadow.min_frame_bits) begin
            f.code = code_reg;
            f.bits = bit_cnt;
            frames_due.push_back(f);
          end
          code_reg = '0;
          bit_cnt = '0;
          pair_cnt = '0;
        end else begin
          last_high = w;
          parse_phase = PH_DATA_LOW;
        end
      end
      default: begin
        if (level) begin
          parse_phase = PH_WAIT;
        end else if (width_near(last_high, cfg_shadow.short_width) &&
                     width_near(w, cfg_shadow.short_width)) begin
          shift_bit(1'b0);
          parse_phase = PH_DATA_HIGH;
        end else if (width_near(last_high, cfg_shadow.long_width) &&
                     width_near(w, cfg_shadow.long_width)) begin
          shift_bit(1'b1);
          parse_phase = PH_DATA_HIGH;
        end else begin
          parse_phase = PH_WAIT;
        end
      end
    endcase
  endtask

  // offer one pulse beat, with random idle cycles ahead of it
  task automatic send_pulse(logic level, logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      pulse_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pulse_ch.valid       <= 1'b1;
    pulse_ch.pulse_level <= level;
    pulse_ch.pulse_width <= w;
    @(posedge clk);
    while (!pulse_ch.ready) @(posedge clk);
    track_pulse(level, w);
    pulses_sent++;
  endtask

  // stop offering and wait for every predicted frame, then let the parser settle
  task automatic drain_frames(int tail);
    int waited;
    waited = 0;
    pulse_ch.valid <= 1'b0;
    while (frames_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (frames_due.size() != 0) begin
      $error("%0d predicted frames never arrived", frames_due.size());
      errors++;
      frames_due.delete();
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_SHORT_WIDTH:  cfg_shadow.short_width = data;
      REG_LONG_WIDTH:   cfg_shadow.long_width = data;
      REG_WIDTH_TOL:    cfg_shadow.width_tolerance = data;
      REG_MIN_BITS:     cfg_shadow.min_frame_bits = data[CNT_W-1:0];
      REG_MIN_PREAMBLE: cfg_shadow.min_preamble_pairs = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // registers change only with the block idle
  task automatic apply_config(pwkd_cfg_t c);
    drain_frames(4);
    write_reg(REG_SHORT_WIDTH, c.short_width);
    write_reg(REG_LONG_WIDTH, c.long_width);
    write_reg(REG_WIDTH_TOL, c.width_tolerance);
    write_reg(REG_MIN_BITS, CFG_W'(c.min_frame_bits));
    write_reg(REG_MIN_PREAMBLE, CFG_W'(c.min_preamble_pairs));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic pwkd_cfg_t cfg_of(int s, int l, int t, int b, int p);
    pwkd_cfg_t c;
    c.short_width        = s[15:0];
    c.long_width         = l[15:0];
    c.width_tolerance    = t[15:0];
    c.min_frame_bits     = b[7:0];
    c.min_preamble_pairs = p[7:0];
    return c;
  endfunction

  // well separated short/long widths with a tolerance that keeps them apart
  function automatic pwkd_cfg_t pick_config();
    int s, l;
    s = $urandom_range(1500, 40);
    l = 2 * s + $urandom_range(2000, 0);
    return cfg_of(s, l, $urandom_range((l - s) / 2, 1), $urandom_range(24, 0),
                  $urandom_range(6, 0));
  endfunction

  // a width that matches nom under the current tolerance, or nom itself when the tolerance is zero
  function automatic logic [15:0] near_pick(logic [15:0] nom);
    int tol, v, off;
    tol = cfg_shadow.width_tolerance;
    v = int'(nom);
    if (tol > 1) begin
      off = int'($urandom_range(tol - 1));
      v = ($urandom_range(1) != 0) ? v + off : v - off;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // a terminator width when one exists, any width otherwise
  function automatic logic [15:0] term_pick();
    int lim;
    lim = term_limit();
    if (lim > 65535) return 16'($urandom_range(65535));
    return 16'($urandom_range(65535, lim));
  endfunction

  // one pulse of a frame, replaced by a random pulse noise_pct times in a hundred
  task automatic emit(logic level, logic [15:0] w, int noise_pct);
    if ($urandom_range(99) < noise_pct)
      send_pulse(1'($urandom_range(1)), 16'($urandom_range(65535)));
    else
      send_pulse(level, w);
  endtask

  // preamble of short pairs, long pair, data pairs, terminator
  task automatic send_frame(int pairs, int nbits, int noise_pct);
    logic b;
    logic [15:0] nom;
    emit(HI, near_pick(cfg_shadow.short_width), noise_pct);
    repeat (pairs) begin
      emit(LO, near_pick(cfg_shadow.short_width), noise_pct);
      emit(HI, near_pick(cfg_shadow.short_width), noise_pct);
    end
    emit(HI, near_pick(cfg_shadow.long_width), noise_pct);
    emit(LO, near_pick(cfg_shadow.long_width), noise_pct);
    repeat (nbits) begin
      b = 1'($urandom_range(1));
      nom = b ? cfg_shadow.long_width : cfg_shadow.short_width;
      emit(HI, near_pick(nom), noise_pct);
      emit(LO, near_pick(nom), noise_pct);
    end
    emit(HI, term_pick(), noise_pct);
  endtask

  // field extremes, tolerance edges, mismatch, reported and short frames
  task automatic test_directed();
    logic [16:0] seq[$];
    seq = '{{LO, 16'd0}, {HI, WMAX}, {LO, WMAX}, {HI, 16'd0}};
    foreach (seq[i]) send_pulse(seq[i][16], seq[i][15:0]);
    apply_config(cfg_of(256, 512, 100, 2, 1));
    seq = '{{HI, 16'd256}, {LO, 16'd157}, {HI, 16'd611}, {LO, 16'd413},
            {HI, 16'd156}, {LO, 16'd256},
            {HI, 16'd256}, {HI, 16'd512}, {LO, 16'd512},
            {HI, 16'd256}, {LO, 16'd256}, {HI, 16'd512}, {LO, 16'd512},
            {HI, WMAX},
            {HI, 16'd256}, {HI, 16'd512}, {LO, 16'd512},
            {HI, 16'd512}, {LO, 16'd512}, {HI, 16'd812}};
    foreach (seq[i]) send_pulse(seq[i][16], seq[i][15:0]);
  endtask

  // zero minimum bits and pairs: empty frame; then frames just short of and at the minimum
  task automatic test_empty_and_short_frames();
    apply_config(cfg_of(100, 300, 20, 0, 0));
    send_frame(0, 0, 0);
    send_frame(2, 3, 0);
    apply_config(cfg_of(100, 300, 20, 4, 0));
    send_frame(1, 3, 0);
    send_frame(1, 4, 0);
  endtask

  // both counters run past 255, code keeps the newest 64 bits
  task automatic test_counter_saturation();
    logic b;
    logic [15:0] nom;
    apply_config(cfg_of(100, 200, 30, 255, 255));
    // short lows back to back each count one more preamble pair
    send_pulse(HI, near_pick(cfg_shadow.short_width));
    repeat (260) send_pulse(LO, near_pick(cfg_shadow.short_width));
    send_pulse(HI, near_pick(cfg_shadow.long_width));
    send_pulse(LO, near_pick(cfg_shadow.long_width));
    repeat (260) begin
      b = 1'($urandom_range(1));
      nom = b ? cfg_shadow.long_width : cfg_shadow.short_width;
      send_pulse(HI, near_pick(nom));
      send_pulse(LO, near_pick(nom));
    end
    send_pulse(HI, term_pick());
    send_frame(3, 1, 0);
  endtask

  // unreachable terminator, zero tolerance, widest tolerance
  task automatic test_width_extremes();
    apply_config(cfg_of(1, 65535, 5, 0, 0));
    send_frame(1, 3, 0);
    send_pulse(HI, WMAX);
    apply_config(cfg_of(300, 700, 0, 0, 0));
    repeat (3) send_frame(2, 4, 0);
    apply_config(cfg_of(1000, 2000, 65535, 0, 0));
    repeat (20) send_pulse(1'($urandom_range(1)), 16'($urandom_range(65535)));
    repeat (2) send_frame(1, 2, 0);
  endtask

  // indexes past the last register must leave the settings alone
  task automatic test_spare_indexes();
    apply_config(cfg_of(150, 400, 50, 3, 2));
    for (int i = REG_MIN_PREAMBLE + 1; i < 2 ** IDX_W; i++)
      write_reg(i[IDX_W-1:0], 16'($urandom_range(65535)));
    cfg_we <= 1'b0;
    repeat (3) send_frame(2, $urandom_range(8, 2), 0);
  endtask

  // receiver holds off while the sender keeps offering short frames
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_config(cfg_of(100, 300, 40, 0, 0));
    fork
      repeat (12) send_frame(0, $urandom_range(2), 0);
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join
  endtask

  // mostly well formed frames with random content, some noise and broken frames
  task automatic test_random_traffic(int send_pct, int stall_pct, int n_items);
    int start, since_cfg;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    start = pulses_sent;
    apply_config(pick_config());
    since_cfg = pulses_sent;
    while (pulses_sent - start < n_items) begin
      if (pulses_sent - since_cfg > 120) begin
        apply_config(pick_config());
        since_cfg = pulses_sent;
      end
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(4, 1))
          send_pulse(1'($urandom_range(1)), 16'($urandom_range(65535)));
      send_frame($urandom_range(cfg_shadow.min_preamble_pairs + 2),
                 $urandom_range(cfg_shadow.min_frame_bits + 8),
                 ($urandom_range(99) < 20) ? 3 : 0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    pulse_ch.valid = 1'b0;
    pulse_ch.pulse_level = 1'b0;
    pulse_ch.pulse_width = '0;
    cfg_shadow  = '{SHORT_WIDTH_RST, LONG_WIDTH_RST, WIDTH_TOL_RST, MIN_BITS_RST,
                    MIN_PREAMBLE_RST};
    parse_phase = PH_WAIT;
    last_high   = '0;
    pair_cnt    = '0;
    code_reg    = '0;
    bit_cnt     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_empty_and_short_frames();
    test_counter_saturation();
    test_width_extremes();
    test_spare_indexes();
    test_backpressure();
    test_random_traffic(0, 0, 40);
    test_random_traffic(81, 0, 40);
    test_random_traffic(0, 81, 40);
    test_random_traffic(25, 25, 40);

    drain_frames(8);
    $display("%0d pulse beats over %0d register settings, %0d frame beats checked",
             pulses_sent, settings_used, frames_checked);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/pwkd_pkg.sv
hw/rtl/pwkd_if.sv
hw/rtl/pwkd_cfg_regs.sv
hw/rtl/pwkd_near.sv
hw/rtl/pwkd_parser.sv
hw/rtl/pulse_width_keyfob_decoder.sv
test/tb.sv
